### hdl/imu_pkg.sv
// Shared types, constants and helpers for the integer math unit.
// Used by imu_ctrl, imu_dp and integer_math_unit; depends on nothing.
package imu_pkg;

   // Word width and derived widths.
   localparam int DataWidth = 32;
   localparam int CntWidth  = $clog2(DataWidth);
   localparam int OpWidth   = 5;

   // Operation codes held in the configuration register.
   localparam logic [OpWidth-1:0] OP_ADD      = 5'd0;
   localparam logic [OpWidth-1:0] OP_SUB      = 5'd1;
   localparam logic [OpWidth-1:0] OP_MUL      = 5'd2;
   localparam logic [OpWidth-1:0] OP_DIV      = 5'd3;
   localparam logic [OpWidth-1:0] OP_DIVFLOOR = 5'd4;
   localparam logic [OpWidth-1:0] OP_DIVCEIL  = 5'd5;
   localparam logic [OpWidth-1:0] OP_DIVROUND = 5'd6;
   localparam logic [OpWidth-1:0] OP_POW      = 5'd7;
   localparam logic [OpWidth-1:0] OP_MADD     = 5'd8;
   localparam logic [OpWidth-1:0] OP_FMOD     = 5'd9;
   localparam logic [OpWidth-1:0] OP_MOD      = 5'd10;
   localparam logic [OpWidth-1:0] OP_ABS      = 5'd11;
   localparam logic [OpWidth-1:0] OP_SIGN     = 5'd12;
   localparam logic [OpWidth-1:0] OP_MIN      = 5'd13;
   localparam logic [OpWidth-1:0] OP_MAX      = 5'd14;
   localparam logic [OpWidth-1:0] OP_GCD      = 5'd15;
   localparam logic [OpWidth-1:0] OP_LCM      = 5'd16;
   localparam logic [OpWidth-1:0] OP_NEG      = 5'd17;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic mul;
      logic div_step;
      logic div_init_lcm;
      logic pow_mul;
      logic pow_sq;
      logic gcd_step;
      logic lcm_mul;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [OpWidth-1:0] op;
      logic               b_neg;
      logic               pow_done;
      logic               div_last;
      logic               gcd_done;
      logic               lcm_zero;
      logic               out_free;
   } sts_type;

   // Magnitude of a two's complement word (the most negative value maps to 2^(W-1)).
   function automatic logic [DataWidth-1:0] mag(input logic [DataWidth-1:0] x);
      mag = x[DataWidth-1] ? (~x + 1'b1) : x;
   endfunction

   // Two's complement negation, wrapping.
   function automatic logic [DataWidth-1:0] neg(input logic [DataWidth-1:0] x);
      neg = ~x + 1'b1;
   endfunction

endpackage

### hdl/imu_ctrl.sv
// Controller state machine of the integer math unit.
// Sequences the datapath through commands; depends on imu_pkg.
module imu_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  imu_pkg::sts_type sts,
   output imu_pkg::cmd_type cmd
);

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_MUL     = 9'b000000010,
      ST_DIV     = 9'b000000100,
      ST_POW_M   = 9'b000001000,
      ST_POW_S   = 9'b000010000,
      ST_GCD     = 9'b000100000,
      ST_LCM_MUL = 9'b001000000,
      ST_FINISH  = 9'b010000000,
      ST_LCM_DIV = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      is_div_op;

   assign is_div_op = (sts.op == imu_pkg::OP_DIV) || (sts.op == imu_pkg::OP_DIVFLOOR) ||
                      (sts.op == imu_pkg::OP_DIVCEIL) || (sts.op == imu_pkg::OP_DIVROUND) ||
                      (sts.op == imu_pkg::OP_FMOD) || (sts.op == imu_pkg::OP_MOD);

   assign req_ready = (state_ff == ST_IDLE);

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if ((sts.op == imu_pkg::OP_MUL) || (sts.op == imu_pkg::OP_MADD)) begin
                  state_in = ST_MUL;
               end else if (is_div_op) begin
                  state_in = ST_DIV;
               end else if (sts.op == imu_pkg::OP_POW) begin
                  state_in = ST_POW_M;
               end else if ((sts.op == imu_pkg::OP_GCD) || (sts.op == imu_pkg::OP_LCM)) begin
                  state_in = ST_GCD;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_FINISH;
         end
         ST_DIV, ST_LCM_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = (state_ff == ST_LCM_DIV) ? ST_LCM_MUL : ST_FINISH;
            end
         end
         ST_POW_M: begin
            if (sts.b_neg || sts.pow_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.pow_mul = 1'b1;
               state_in    = ST_POW_S;
            end
         end
         ST_POW_S: begin
            cmd.pow_sq = 1'b1;
            state_in   = ST_POW_M;
         end
         ST_GCD: begin
            if (!sts.gcd_done) begin
               cmd.gcd_step = 1'b1;
            end else if ((sts.op == imu_pkg::OP_LCM) && !sts.lcm_zero) begin
               cmd.div_init_lcm = 1'b1;
               state_in         = ST_LCM_DIV;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_LCM_MUL: begin
            cmd.lcm_mul = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hdl/imu_dp.sv
// Datapath of the integer math unit: operand registers, shared multiplier,
// shift-subtract divider, binary gcd and the output register; depends on imu_pkg.
module imu_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_en,
   input  logic [imu_pkg::OpWidth-1:0]           csr_write_data,
   input  logic signed [imu_pkg::DataWidth-1:0]  req_operand_a,
   input  logic signed [imu_pkg::DataWidth-1:0]  req_operand_b,
   input  logic signed [imu_pkg::DataWidth-1:0]  req_operand_c,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [imu_pkg::DataWidth-1:0]  rsp_result,
   input  imu_pkg::cmd_type                      cmd,
   output imu_pkg::sts_type                      sts
);

   localparam int W = imu_pkg::DataWidth;
   localparam int C = imu_pkg::CntWidth;

   logic [imu_pkg::OpWidth-1:0] op_ff;
   logic [W-1:0] a_ff, b_ff, c_ff;
   logic [W-1:0] rem_ff, quo_ff, dvs_ff;
   logic [C-1:0] cnt_ff;
   logic [W-1:0] acc_ff, sq_ff, ebits_ff, prod_ff;
   logic [W-1:0] x_ff, y_ff;
   logic [C-1:0] k_ff;
   logic         valid_ff;
   logic [W-1:0] result_ff;

   logic         na, nb;
   logic [W-1:0] ma, mb;
   logic [W:0]   trial;
   logic [W:0]   trial_sub;
   logic [W-1:0] mul_x, mul_y;
   logic [2*W-1:0] mul_full;
   logic [W-1:0] mul_lo;
   logic [W-1:0] gcd_val;
   logic [W-1:0] result_in;

   // Operand signs and magnitudes.
   assign na = a_ff[W-1];
   assign nb = b_ff[W-1];
   assign ma = imu_pkg::mag(a_ff);
   assign mb = imu_pkg::mag(b_ff);

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= imu_pkg::OP_ADD;
      end else if (csr_write_en) begin
         op_ff <= csr_write_data;
      end
   end

   // One divider step: shift the next dividend bit into the remainder and try to subtract.
   assign trial     = {rem_ff, quo_ff[W-1]};
   assign trial_sub = trial - {1'b0, dvs_ff};

   // Shared multiplier; only the low word is kept.
   always_comb begin
      mul_x = a_ff;
      mul_y = b_ff;
      if (cmd.pow_mul) begin
         mul_x = acc_ff;
         mul_y = sq_ff;
      end else if (cmd.pow_sq) begin
         mul_x = sq_ff;
         mul_y = sq_ff;
      end else if (cmd.lcm_mul) begin
         mul_x = quo_ff;
         mul_y = mb;
      end
   end
   assign mul_full = mul_x * mul_y;
   assign mul_lo   = mul_full[W-1:0];

   // Gcd value once one side has reached zero.
   assign gcd_val = (x_ff | y_ff) << k_ff;

   // Operand, divider, power and gcd registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff     <= req_operand_a;
         b_ff     <= req_operand_b;
         c_ff     <= req_operand_c;
         rem_ff   <= '0;
         quo_ff   <= imu_pkg::mag(req_operand_a);
         dvs_ff   <= imu_pkg::mag(req_operand_b);
         cnt_ff   <= '0;
         acc_ff   <= {{(W-1){1'b0}}, 1'b1};
         sq_ff    <= req_operand_a;
         ebits_ff <= req_operand_b;
         x_ff     <= imu_pkg::mag(req_operand_a);
         y_ff     <= imu_pkg::mag(req_operand_b);
         k_ff     <= '0;
      end
      if (cmd.div_init_lcm) begin
         rem_ff <= '0;
         quo_ff <= ma;
         dvs_ff <= gcd_val;
         cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         if (!trial_sub[W]) begin
            rem_ff <= trial_sub[W-1:0];
         end else begin
            rem_ff <= trial[W-1:0];
         end
         quo_ff <= {quo_ff[W-2:0], ~trial_sub[W]};
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.mul || cmd.lcm_mul) begin
         prod_ff <= mul_lo;
      end
      if (cmd.pow_mul && ebits_ff[0]) begin
         acc_ff <= mul_lo;
      end
      if (cmd.pow_sq) begin
         sq_ff    <= mul_lo;
         ebits_ff <= ebits_ff >> 1;
      end
      // Binary gcd: strip common twos, then odd factors by subtraction.
      if (cmd.gcd_step) begin
         priority if (!x_ff[0] && !y_ff[0]) begin
            x_ff <= x_ff >> 1;
            y_ff <= y_ff >> 1;
            k_ff <= k_ff + 1'b1;
         end else if (!x_ff[0]) begin
            x_ff <= x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_ff <= y_ff >> 1;
         end else if (x_ff >= y_ff) begin
            x_ff <= x_ff - y_ff;
         end else begin
            y_ff <= y_ff - x_ff;
         end
      end
   end

   // Final result selection.
   always_comb begin
      logic [W-1:0] q, r, q1, qr;
      logic         nq, rnz;
      q   = quo_ff;
      r   = rem_ff;
      nq  = na ^ nb;
      rnz = (r != '0);
      q1  = q + {{(W-1){1'b0}}, rnz};
      qr  = (r >= (mb - r)) ? (q + 1'b1) : q;
      result_in = '0;
      unique case (op_ff)
         imu_pkg::OP_ADD:      result_in = a_ff + b_ff;
         imu_pkg::OP_SUB:      result_in = a_ff - b_ff;
         imu_pkg::OP_MUL:      result_in = prod_ff;
         imu_pkg::OP_MADD:     result_in = prod_ff + c_ff;
         imu_pkg::OP_DIV:      result_in = nq ? imu_pkg::neg(q) : q;
         imu_pkg::OP_DIVFLOOR: result_in = nq ? imu_pkg::neg(q1) : q;
         imu_pkg::OP_DIVCEIL:  result_in = nq ? imu_pkg::neg(q) : q1;
         imu_pkg::OP_DIVROUND: result_in = nq ? imu_pkg::neg(qr) : qr;
         imu_pkg::OP_FMOD: begin
            if (rnz && nq) begin
               result_in = nb ? imu_pkg::neg(mb - r) : (mb - r);
            end else begin
               result_in = na ? imu_pkg::neg(r) : r;
            end
         end
         imu_pkg::OP_MOD:      result_in = na ? imu_pkg::neg(r) : r;
         imu_pkg::OP_POW: begin
            if (!nb) begin
               result_in = acc_ff;
            end else if (a_ff == {{(W-1){1'b0}}, 1'b1}) begin
               result_in = a_ff;
            end else if (a_ff == {W{1'b1}}) begin
               result_in = b_ff[0] ? {W{1'b1}} : {{(W-1){1'b0}}, 1'b1};
            end
         end
         imu_pkg::OP_ABS:      result_in = ma;
         imu_pkg::OP_SIGN: begin
            if (a_ff != '0) begin
               result_in = na ? {W{1'b1}} : {{(W-1){1'b0}}, 1'b1};
            end
         end
         imu_pkg::OP_MIN:      result_in = ($signed(a_ff) < $signed(b_ff)) ? a_ff : b_ff;
         imu_pkg::OP_MAX:      result_in = ($signed(a_ff) < $signed(b_ff)) ? b_ff : a_ff;
         imu_pkg::OP_GCD:      result_in = gcd_val;
         imu_pkg::OP_LCM:      result_in = prod_ff;
         imu_pkg::OP_NEG:      result_in = imu_pkg::neg(a_ff);
         default:              result_in = '0;
      endcase
      // A zero divisor gives zero for every divide and modulo.
      if ((mb == '0) && ((op_ff == imu_pkg::OP_DIV) || (op_ff == imu_pkg::OP_DIVFLOOR) ||
                         (op_ff == imu_pkg::OP_DIVCEIL) || (op_ff == imu_pkg::OP_DIVROUND) ||
                         (op_ff == imu_pkg::OP_FMOD) || (op_ff == imu_pkg::OP_MOD))) begin
         result_in = '0;
      end
      // Lcm with a zero operand is zero.
      if ((op_ff == imu_pkg::OP_LCM) && ((ma == '0) || (mb == '0))) begin
         result_in = '0;
      end
   end

   // Output register: holds the word until the consumer takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

   // Status toward the controller.
   assign sts.op       = op_ff;
   assign sts.b_neg    = nb;
   assign sts.pow_done = (ebits_ff == '0);
   assign sts.div_last = (cnt_ff == C'(W-1));
   assign sts.gcd_done = (x_ff == '0) || (y_ff == '0);
   assign sts.lcm_zero = (ma == '0) || (mb == '0);
   assign sts.out_free = !valid_ff || rsp_ready;

endmodule

### hdl/integer_math_unit.sv
// Top level of the integer math unit: joins the controller and the datapath.
// Depends on imu_pkg, imu_ctrl and imu_dp.
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_ready     req_operand_a, _b, _c
//   rsp      out        rsp_valid / rsp_ready     rsp_result
//   csr      in         csr_write_en              csr_write_data (operation)
//
// One word is worked on at a time. Simple operations go from the load to the finish
// state; multiply and multiply-add pass a multiply state; divides and modulos run
// the shift-subtract divider, one quotient bit a cycle; power alternates multiply
// and square on one multiplier; gcd does binary gcd steps, lcm those and the divider.
// Reset is synchronous and clears the controller, the output valid and the operation.
// A finished word waits in the output register while the next word is accepted.
module integer_math_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [imu_pkg::DataWidth-1:0] req_operand_a,
   input  logic signed [imu_pkg::DataWidth-1:0] req_operand_b,
   input  logic signed [imu_pkg::DataWidth-1:0] req_operand_c,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [imu_pkg::DataWidth-1:0] rsp_result,
   input  logic                                 csr_write_en,
   input  logic [imu_pkg::OpWidth-1:0]          csr_write_data
);

   imu_pkg::cmd_type cmd;
   imu_pkg::sts_type sts;

   // Sequencer.
   imu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Arithmetic and result register.
   imu_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_operand_a  (req_operand_a),
      .req_operand_b  (req_operand_b),
      .req_operand_c  (req_operand_c),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_result     (rsp_result),
      .cmd            (cmd),
      .sts            (sts)
   );

endmodule
